[rtl/core/ufdpc_pkg.sv]
// shared types and constants for the uart frame deframer with pin cache
// no dependencies
package ufdpc_pkg;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_BAD_TRL = 3'd1;
  localparam logic [2:0] KIND_BAD_LEN = 3'd2;
  localparam logic [2:0] KIND_NO_SOF  = 3'd3;
  localparam logic [2:0] KIND_PIN_RD  = 3'd4;
  localparam logic [2:0] KIND_FLUSHED = 3'd5;

  localparam logic [7:0] START_BYTE = 8'h53;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] CMD_DIR    = 8'h44;
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_OUT    = 8'h4F;
  localparam logic [7:0] CMD_CFG    = 8'h43;
  localparam logic [7:0] CMD_INFO   = 8'h69;

  localparam int FRAME_OVH   = 5;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 6;

  localparam logic [2:0] REG_NUM_PINS = 3'd0;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] cmd;
    logic [7:0] payload_len;
    logic [7:0] pin_out;
    logic [7:0] value;
    logic [7:0] direction;
    logic       table_updated;
    logic       known_cmd;
  } evt_t;

  typedef struct packed {
    logic       dir_we;
    logic       val_we;
    logic [7:0] pin;
    logic [7:0] data;
  } cache_wr_t;

  typedef struct packed {
    logic       rd_en;
    logic [4:0] pin;
  } cache_rd_t;

endpackage

[rtl/core/uart_frame_deframer_pin_cache_top.sv]
// order: a flush result goes from the pending register to the output register, a pin read
// first through the registered pin cache read; a received byte stalls the input while the
// scan skips bytes before a start byte, stops at a frame still incomplete, drops each frame
// failing its trailer and accepts complete ones; flow: one transaction at a time, the scan
// reads through the single read port of the byte buffer memory; output stalls lengthen it
// reset: synchronous active low, empties the buffer and clears the pin caches, num_pins = 32
module uart_frame_deframer_pin_cache_top #(
  parameter int BUF_BYTES = 64,
  parameter int NUM_PINS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic [4:0]  in_pin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_cmd,
  output logic [7:0]  out_payload_len,
  output logic [7:0]  out_pin_out,
  output logic [7:0]  out_value,
  output logic [7:0]  out_direction,
  output logic        out_table_updated,
  output logic        out_known_cmd,
  output logic        out_last
);

  logic [5:0]           num_pins_r;
  logic                 reg_sel;
  ufdpc_pkg::cache_rd_t crd;
  ufdpc_pkg::cache_wr_t cwr;
  logic [7:0]           c_dir;
  logic [7:0]           c_val;
  logic                 start;
  logic                 evt_valid;
  ufdpc_pkg::evt_t      evt;
  logic                 flush;
  logic                 emit_ok;
  logic                 flush_done;
  ufdpc_pkg::evt_t      out_evt;

  assign reg_sel    = (cfg_paddr[2] == ufdpc_pkg::REG_NUM_PINS[0]);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {26'd0, num_pins_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pins_r <= 6'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      num_pins_r <= cfg_pwdata[5:0];
    end
  end

  ufdpc_scan #(
    .BUF_BYTES (BUF_BYTES),
    .NUM_PINS  (NUM_PINS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .in_pin     (in_pin),
    .num_pins   (num_pins_r),
    .crd        (crd),
    .cwr        (cwr),
    .c_dir      (c_dir),
    .c_val      (c_val),
    .start      (start),
    .evt_valid  (evt_valid),
    .evt        (evt),
    .flush      (flush),
    .emit_ok    (emit_ok),
    .flush_done (flush_done)
  );

  ufdpc_cache #(
    .NUM_PINS (NUM_PINS)
  ) u_cache (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd     (crd),
    .wr     (cwr),
    .rd_dir (c_dir),
    .rd_val (c_val)
  );

  ufdpc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .evt_valid  (evt_valid),
    .evt        (evt),
    .flush      (flush),
    .emit_ok    (emit_ok),
    .flush_done (flush_done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_evt    (out_evt),
    .out_last   (out_last)
  );

  assign out_kind          = out_evt.kind;
  assign out_cmd           = out_evt.cmd;
  assign out_payload_len   = out_evt.payload_len;
  assign out_pin_out       = out_evt.pin_out;
  assign out_value         = out_evt.value;
  assign out_direction     = out_evt.direction;
  assign out_table_updated = out_evt.table_updated;
  assign out_known_cmd     = out_evt.known_cmd;

endmodule

[rtl/core/ufdpc_cache.sv]
// per-pin direction and value cache memories with valid bits
// depends on ufdpc_pkg
module ufdpc_cache #(
  parameter int NUM_PINS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ufdpc_pkg::cache_rd_t rd,
  input  ufdpc_pkg::cache_wr_t wr,
  output logic [7:0]           rd_dir,
  output logic [7:0]           rd_val
);

  localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  logic [7:0]          dir_mem [NUM_PINS];
  logic [7:0]          val_mem [NUM_PINS];
  logic [NUM_PINS-1:0] dir_vld_r;
  logic [NUM_PINS-1:0] val_vld_r;
  logic [7:0]          dir_q_r;
  logic [7:0]          val_q_r;
  logic                dv_r;
  logic                vv_r;
  logic [PW-1:0]       ra;
  logic [PW-1:0]       wa;
  logic                rd_in;

  assign ra    = PW'({3'd0, rd.pin});
  assign wa    = PW'(wr.pin);
  assign rd_in = ({4'd0, rd.pin} < 9'(NUM_PINS));

  always_ff @(posedge clk) begin
    if (wr.dir_we) begin
      dir_mem[wa] <= wr.data;
    end
    if (wr.val_we) begin
      val_mem[wa] <= wr.data;
    end
    if (rd.rd_en) begin
      dir_q_r <= dir_mem[ra];
      val_q_r <= val_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_vld_r <= '0;
      val_vld_r <= '0;
      dv_r      <= 1'b0;
      vv_r      <= 1'b0;
    end else begin
      if (wr.dir_we) begin
        dir_vld_r[wa] <= 1'b1;
      end
      if (wr.val_we) begin
        val_vld_r[wa] <= 1'b1;
      end
      if (rd.rd_en) begin
        dv_r <= rd_in && dir_vld_r[ra];
        vv_r <= rd_in && val_vld_r[ra];
      end
    end
  end

  assign rd_dir = dv_r ? dir_q_r : 8'd0;
  assign rd_val = vv_r ? val_q_r : 8'd0;

endmodule

[rtl/core/ufdpc_outq.sv]
// result holding stage and output register, marks the last result of a transaction
// depends on ufdpc_pkg
module ufdpc_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            evt_valid,
  input  ufdpc_pkg::evt_t evt,
  input  logic            flush,
  output logic            emit_ok,
  output logic            flush_done,
  output logic            out_valid,
  input  logic            out_stall,
  output ufdpc_pkg::evt_t out_evt,
  output logic            out_last
);

  ufdpc_pkg::evt_t pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  ufdpc_pkg::evt_t oevt_r, oevt_nxt;
  logic            olast_r, olast_nxt;
  logic            ovld_r, ovld_nxt;
  logic [ufdpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic            out_free;
  logic            push;

  assign out_free   = !ovld_r || !out_stall;
  assign emit_ok    = !pend_vld_r || out_free;
  assign flush_done = !pend_vld_r;
  assign cnt_eff    = start ? '0 : cnt_r;
  assign push       = evt_valid && (cnt_eff < ufdpc_pkg::CNT_W'(ufdpc_pkg::MAX_RESULTS));

  always_comb begin
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    oevt_nxt     = oevt_r;
    olast_nxt    = olast_r;
    ovld_nxt     = ovld_r;
    cnt_nxt      = cnt_eff;
    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
    if (push) begin
      cnt_nxt = cnt_eff + 1'b1;
      if (pend_vld_r) begin
        oevt_nxt  = pend_r;
        olast_nxt = 1'b0;
        ovld_nxt  = 1'b1;
      end
      pend_nxt     = evt;
      pend_vld_nxt = 1'b1;
    end else if (flush && pend_vld_r && out_free) begin
      oevt_nxt     = pend_r;
      olast_nxt    = 1'b1;
      ovld_nxt     = 1'b1;
      pend_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      ovld_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      ovld_r     <= ovld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r  <= pend_nxt;
    oevt_r  <= oevt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ovld_r;
  assign out_evt   = oevt_r;
  assign out_last  = olast_r;

`ifndef SYNTHESIS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ufdpc_pkg::CNT_W'(ufdpc_pkg::MAX_RESULTS))
    else $error("result count over limit");
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (flush && !evt_valid && pend_vld_r && out_free) |=> (ovld_r && olast_r && !pend_vld_r))
    else $error("pending result not released as last");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && out_stall) |=> (ovld_r && $stable(oevt_r) && $stable(olast_r)))
    else $error("stalled result changed");
`endif

endmodule

[rtl/core/ufdpc_scan.sv]
// byte buffer memory and frame scan sequencer
// depends on ufdpc_pkg
module ufdpc_scan #(
  parameter int BUF_BYTES = 64,
  parameter int NUM_PINS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_rx_byte,
  input  logic [4:0]           in_pin,
  input  logic [5:0]           num_pins,
  output ufdpc_pkg::cache_rd_t crd,
  output ufdpc_pkg::cache_wr_t cwr,
  input  logic [7:0]           c_dir,
  input  logic [7:0]           c_val,
  output logic                 start,
  output logic                 evt_valid,
  output ufdpc_pkg::evt_t      evt,
  output logic                 flush,
  input  logic                 emit_ok,
  input  logic                 flush_done
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_LEN   = 4'd3;
  localparam logic [3:0] S_T1    = 4'd4;
  localparam logic [3:0] S_T2    = 4'd5;
  localparam logic [3:0] S_CMD   = 4'd6;
  localparam logic [3:0] S_PIN   = 4'd7;
  localparam logic [3:0] S_VAL   = 4'd8;
  localparam logic [3:0] S_PRD   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [7:0]    buf_mem [BUF_BYTES];
  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [7:0]    rdata_r;
  logic [7:0]    dlen_r, dlen_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    pin_r, pin_nxt;
  logic          cr_ok_r, cr_ok_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] fill_w;
  logic [LW-1:0] flen_rd;
  logic [LW-1:0] flen_d;
  logic          upd_ok;

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] hd, input logic [LW-1:0] idx);
    logic [LW:0] s;
    s = (LW+1)'(hd) + (LW+1)'(idx);
    if (s >= (LW+1)'(BUF_BYTES)) begin
      s = s - (LW+1)'(BUF_BYTES);
    end
    return s[AW-1:0];
  endfunction

  assign fill_w  = LW'(fill_r);
  assign flen_rd = LW'(rdata_r) + LW'(ufdpc_pkg::FRAME_OVH);
  assign flen_d  = LW'(dlen_r) + LW'(ufdpc_pkg::FRAME_OVH);
  assign upd_ok  = (dlen_r == 8'd2) && (pin_r < {2'd0, num_pins})
                   && ({1'b0, pin_r} < 9'(NUM_PINS));
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    rd_addr_nxt = rd_addr_r;
    dlen_nxt    = dlen_r;
    cmd_nxt     = cmd_r;
    pin_nxt     = pin_r;
    cr_ok_nxt   = cr_ok_r;
    wr_en       = 1'b0;
    wr_addr     = addr_of(head_r, fill_w);
    crd         = '0;
    cwr         = '0;
    cwr.pin     = pin_r;
    cwr.data    = rdata_r;
    start       = 1'b0;
    evt_valid   = 1'b0;
    evt         = '0;
    flush       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          start = 1'b1;
          case (in_op)
            ufdpc_pkg::OP_BYTE: begin
              if (fill_w == LW'(BUF_BYTES)) begin
                fill_nxt  = '0;
                evt_valid = 1'b1;
                evt.kind  = ufdpc_pkg::KIND_FLUSHED;
                state_nxt = S_FIN;
              end else begin
                wr_en     = 1'b1;
                fill_nxt  = fill_r + 1'b1;
                state_nxt = S_SCAN;
              end
            end
            ufdpc_pkg::OP_READ: begin
              crd.rd_en = 1'b1;
              crd.pin   = in_pin;
              pin_nxt   = {3'd0, in_pin};
              state_nxt = S_PRD;
            end
            ufdpc_pkg::OP_FLUSH: begin
              fill_nxt  = '0;
              evt_valid = 1'b1;
              evt.kind  = ufdpc_pkg::KIND_FLUSHED;
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (fill_w >= LW'(ufdpc_pkg::FRAME_OVH)) begin
          rd_addr_nxt = head_r;
          state_nxt   = S_START;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_START: begin
        if (emit_ok) begin
          if (rdata_r == ufdpc_pkg::START_BYTE) begin
            if (fill_w < LW'(ufdpc_pkg::FRAME_OVH)) begin
              state_nxt = S_FIN;
            end else begin
              rd_addr_nxt = addr_of(head_r, LW'(2));
              state_nxt   = S_LEN;
            end
          end else if (fill_w == LW'(1)) begin
            fill_nxt  = '0;
            evt_valid = 1'b1;
            evt.kind  = ufdpc_pkg::KIND_NO_SOF;
            state_nxt = S_FIN;
          end else begin
            head_nxt    = addr_of(head_r, LW'(1));
            fill_nxt    = fill_r - 1'b1;
            rd_addr_nxt = addr_of(head_r, LW'(1));
          end
        end
      end
      S_LEN: begin
        if (emit_ok) begin
          dlen_nxt = rdata_r;
          if (flen_rd > LW'(BUF_BYTES)) begin
            fill_nxt  = '0;
            evt_valid = 1'b1;
            evt.kind  = ufdpc_pkg::KIND_BAD_LEN;
            state_nxt = S_FIN;
          end else if (fill_w < flen_rd) begin
            state_nxt = S_FIN;
          end else begin
            rd_addr_nxt = addr_of(head_r, flen_rd - LW'(2));
            state_nxt   = S_T1;
          end
        end
      end
      S_T1: begin
        cr_ok_nxt   = (rdata_r == ufdpc_pkg::CR_BYTE);
        rd_addr_nxt = addr_of(head_r, flen_d - LW'(1));
        state_nxt   = S_T2;
      end
      S_T2: begin
        if (emit_ok) begin
          if (!cr_ok_r || rdata_r != ufdpc_pkg::LF_BYTE) begin
            head_nxt  = addr_of(head_r, LW'(1));
            fill_nxt  = fill_r - 1'b1;
            evt_valid = 1'b1;
            evt.kind  = ufdpc_pkg::KIND_BAD_TRL;
            state_nxt = S_SCAN;
          end else begin
            rd_addr_nxt = addr_of(head_r, LW'(1));
            state_nxt   = S_CMD;
          end
        end
      end
      S_CMD: begin
        cmd_nxt     = rdata_r;
        rd_addr_nxt = addr_of(head_r, LW'(3));
        state_nxt   = S_PIN;
      end
      S_PIN: begin
        pin_nxt     = rdata_r;
        rd_addr_nxt = addr_of(head_r, LW'(4));
        state_nxt   = S_VAL;
      end
      S_VAL: begin
        if (emit_ok) begin
          evt_valid       = 1'b1;
          evt.kind        = ufdpc_pkg::KIND_ACCEPT;
          evt.cmd         = cmd_r;
          evt.payload_len = dlen_r;
          evt.pin_out     = pin_r;
          evt.value       = rdata_r;
          if (cmd_r == ufdpc_pkg::CMD_DIR) begin
            evt.known_cmd     = 1'b1;
            evt.direction     = rdata_r;
            evt.table_updated = upd_ok;
            cwr.dir_we        = upd_ok;
          end else if (cmd_r inside {ufdpc_pkg::CMD_READ, ufdpc_pkg::CMD_OUT}) begin
            evt.known_cmd     = 1'b1;
            evt.table_updated = upd_ok;
            cwr.val_we        = upd_ok;
          end else if (cmd_r inside {ufdpc_pkg::CMD_CFG, ufdpc_pkg::CMD_INFO}) begin
            evt.known_cmd = 1'b1;
          end
          head_nxt  = addr_of(head_r, flen_d);
          fill_nxt  = CW'(fill_w - flen_d);
          state_nxt = S_SCAN;
        end
      end
      S_PRD: begin
        if (emit_ok) begin
          evt_valid     = 1'b1;
          evt.kind      = ufdpc_pkg::KIND_PIN_RD;
          evt.pin_out   = pin_r;
          evt.value     = c_val;
          evt.direction = c_dir;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        flush = 1'b1;
        if (flush_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // buffer write happens only on accept, reads are issued from later states
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= in_rx_byte;
    end
    rdata_r <= buf_mem[rd_addr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      fill_r    <= '0;
      rd_addr_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      rd_addr_r <= rd_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dlen_r  <= dlen_nxt;
    cmd_r   <= cmd_nxt;
    pin_r   <= pin_nxt;
    cr_ok_r <= cr_ok_nxt;
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_w <= LW'(BUF_BYTES))
    else $error("fill count over buffer size");
  a_cache_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (cwr.dir_we || cwr.val_we) |-> (state_r == S_VAL && !(cwr.dir_we && cwr.val_we)))
    else $error("cache write outside frame accept");
  a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    evt_valid |-> emit_ok)
    else $error("event raised while result path blocked");
`endif

endmodule
